/* design/lrupr_pkg.sv */
// lrupr_pkg: shared types and fixed constants of the lru page replacement unit
// used by lrupr_frame_table and lru_page_replacement_unit, no dependencies
package lrupr_pkg;

    localparam int CFG_W   = 5;
    localparam int COUNT_W = 32;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(3);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    typedef struct packed {
        logic page_fault;
        logic evicted_valid;
    } t_status;

endpackage

/* design/lrupr_frame_table.sv */
// lrupr_frame_table: resident page table with recency ranks, occupancy and fault count
// lookup, victim choice and rank update are combinational; state moves on i_advance
// depends on lrupr_pkg
module lrupr_frame_table #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 20,
    parameter int SLOT_W     = 4,
    parameter int CNT_W      = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [PAGE_BITS-1:0]         i_page,
    input  logic [lrupr_pkg::CFG_W-1:0]  i_frames_in_use,
    output lrupr_pkg::t_status           o_status,
    output logic [SLOT_W-1:0]            o_slot,
    output logic [PAGE_BITS-1:0]         o_evicted_page,
    output logic [CNT_W-1:0]             o_resident_count,
    output logic [lrupr_pkg::COUNT_W-1:0] o_fault_total
);

    localparam int CMP_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;

    logic [PAGE_BITS-1:0]          r_pages [MAX_FRAMES];
    logic [SLOT_W-1:0]             r_rank  [MAX_FRAMES];
    logic [SLOT_W-1:0]             n_rank  [MAX_FRAMES];
    logic [CNT_W-1:0]              r_occ;
    logic [CNT_W-1:0]              n_occ;
    logic [lrupr_pkg::COUNT_W-1:0] r_faults;
    logic [lrupr_pkg::COUNT_W-1:0] n_faults;

    logic [MAX_FRAMES-1:0] occ_mask;
    logic [MAX_FRAMES-1:0] hit_vec;
    logic [MAX_FRAMES-1:0] lru_vec;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     lru_idx;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_W-1:0]     old_rank;
    logic [CMP_W-1:0]      limit;
    logic                  hit;
    logic                  fill;

    // parallel match and lru search
    always_comb begin
        occ_mask = '0;
        hit_vec  = '0;
        lru_vec  = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            occ_mask[i] = CNT_W'(i) < r_occ;
            hit_vec[i]  = occ_mask[i] && (r_pages[i] == i_page);
            lru_vec[i]  = occ_mask[i] && (CNT_W'(r_rank[i]) == (r_occ - CNT_W'(1)));
        end
    end

    // lowest index wins
    always_comb begin
        hit_idx = '0;
        lru_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (lru_vec[i]) begin
                lru_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (i_frames_in_use == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(i_frames_in_use) > CMP_W'(MAX_FRAMES)) begin
            limit = CMP_W'(MAX_FRAMES);
        end else begin
            limit = CMP_W'(i_frames_in_use);
        end
    end

    assign hit  = |hit_vec;
    assign fill = !hit && (CMP_W'(r_occ) < limit);

    always_comb begin
        if (hit) begin
            slot     = hit_idx;
            old_rank = r_rank[hit_idx];
        end else if (fill) begin
            slot     = r_occ[SLOT_W-1:0];
            old_rank = '1;
        end else begin
            slot     = lru_idx;
            old_rank = SLOT_W'(r_occ - CNT_W'(1));
        end
    end

    // recency update
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (SLOT_W'(i) == slot) begin
                n_rank[i] = '0;
            end else if (occ_mask[i] && (fill || (r_rank[i] < old_rank))) begin
                n_rank[i] = r_rank[i] + SLOT_W'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    always_comb begin
        n_occ    = fill ? r_occ + CNT_W'(1) : r_occ;
        n_faults = r_faults;
        if (!hit && (r_faults != lrupr_pkg::COUNT_MAX)) begin
            n_faults = r_faults + lrupr_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_faults <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_advance) begin
            r_occ    <= n_occ;
            r_faults <= n_faults;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && !hit) begin
            r_pages[slot] <= i_page;
        end
    end

    assign o_status.page_fault    = !hit;
    assign o_status.evicted_valid = !hit && !fill;
    assign o_slot                 = slot;
    assign o_evicted_page         = (!hit && !fill) ? r_pages[lru_idx] : '0;
    assign o_resident_count       = n_occ;
    assign o_fault_total          = n_faults;

endmodule

/* design/lru_page_replacement_unit.sv */
// lru_page_replacement_unit: top level with input item register, frame table, result register
// depends on lrupr_pkg and lrupr_frame_table
// path: input register, then result register, which loads once it is empty or being read
// throughput: one item per cycle while i_ready holds, set by the combinational table update
// reset: synchronous active low; clears occupancy, ranks, fault count and both stage valids,
// sets frames_in_use to 3; page storage is not cleared and needs no clearing pass
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 20
) (
    i_clk, i_rst_n, i_valid, o_ready, i_page_number, o_valid, i_ready,
    o_page_fault, o_frame_slot, o_evicted_valid, o_evicted_page,
    o_resident_count, o_fault_total, i_cfg_we, i_cfg_data
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

    input  logic                          i_clk;
    input  logic                          i_rst_n;
    input  logic                          i_valid;
    output logic                          o_ready;
    input  logic [PAGE_BITS-1:0]          i_page_number;
    output logic                          o_valid;
    input  logic                          i_ready;
    output logic                          o_page_fault;
    output logic [SLOT_W-1:0]             o_frame_slot;
    output logic                          o_evicted_valid;
    output logic [PAGE_BITS-1:0]          o_evicted_page;
    output logic [CNT_W-1:0]              o_resident_count;
    output logic [lrupr_pkg::COUNT_W-1:0] o_fault_total;
    input  logic                          i_cfg_we;
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_data;

    logic [lrupr_pkg::CFG_W-1:0]   r_frames_in_use;
    logic                          r_in_valid;
    logic [PAGE_BITS-1:0]          r_in_page;
    logic                          r_out_valid;
    lrupr_pkg::t_status            r_status;
    logic [SLOT_W-1:0]             r_slot;
    logic [PAGE_BITS-1:0]          r_ev_page;
    logic [CNT_W-1:0]              r_count;
    logic [lrupr_pkg::COUNT_W-1:0] r_total;

    lrupr_pkg::t_status            n_status;
    logic [SLOT_W-1:0]             n_slot;
    logic [PAGE_BITS-1:0]          n_ev_page;
    logic [CNT_W-1:0]              n_count;
    logic [lrupr_pkg::COUNT_W-1:0] n_total;

    logic advance;
    logic in_take;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    lrupr_frame_table #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_table (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_page           (r_in_page),
        .i_frames_in_use  (r_frames_in_use),
        .o_status         (n_status),
        .o_slot           (n_slot),
        .o_evicted_page   (n_ev_page),
        .o_resident_count (n_count),
        .o_fault_total    (n_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lrupr_pkg::FRAMES_RESET;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_page <= i_page_number;
        end
        if (advance) begin
            r_status  <= n_status;
            r_slot    <= n_slot;
            r_ev_page <= n_ev_page;
            r_count   <= n_count;
            r_total   <= n_total;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_page_fault     = r_status.page_fault;
    assign o_evicted_valid  = r_status.evicted_valid;
    assign o_frame_slot     = r_slot;
    assign o_evicted_page   = r_ev_page;
    assign o_resident_count = r_count;
    assign o_fault_total    = r_total;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for lru_page_replacement_unit
// predicts each result item with its own lru frame table, drives directed then random references
// depends on lrupr_pkg and the design sources
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W           = lrupr_pkg::CFG_W;
    localparam int COUNT_W         = lrupr_pkg::COUNT_W;
    localparam int NUM_FRAMES      = 16;
    localparam int PAGE_W          = 20;
    localparam int SLOT_W          = $clog2(NUM_FRAMES);
    localparam int POOL_SIZE       = 24;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 161;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;

    localparam logic [CFG_W-1:0] PHASE_FRAMES [NUM_PHASES] =
        '{5'd3, 5'd1, 5'd0, 5'd5, 5'd16, 5'd2, 5'd31, 5'd8, 5'd17, 5'd12, 5'd4, 5'd16};

    localparam logic [PAGE_W-1:0] DIRECTED_PAGES [14] = '{
        20'h00000, 20'hFFFFF, 20'h00000, 20'hAAAAA, 20'hFFFFF, 20'h55555, 20'h00000,
        20'hAAAAA, 20'h55555, 20'h55555, 20'h12345, 20'hFFFFF, 20'h00000, 20'hEDCBA
    };

    typedef struct {
        logic               page_fault;
        logic [SLOT_W-1:0]  frame_slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [CFG_W-1:0]   resident_count;
        logic [COUNT_W-1:0] fault_total;
    } t_lookup_outcome;

    class t_lru_scoreboard;
        logic [PAGE_W-1:0]  frame_page [NUM_FRAMES];
        int unsigned        frame_age [NUM_FRAMES];
        int unsigned        occupied;
        logic [COUNT_W-1:0] faults;
        logic [CFG_W-1:0]   frames_cfg;
        t_lookup_outcome    outcomes [$];
        int                 mismatches;

        function new();
            occupied   = 0;
            faults     = '0;
            frames_cfg = lrupr_pkg::FRAMES_RESET;
            mismatches = 0;
            foreach (frame_age[i]) frame_age[i] = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames_cfg = value;
        endfunction

        function int unsigned frame_limit();
            if (frames_cfg == 0) return 1;
            if (frames_cfg > NUM_FRAMES) return NUM_FRAMES;
            return frames_cfg;
        endfunction

        function int unsigned pending();
            return outcomes.size();
        endfunction

        // frame f becomes most recent, younger frames age by one
        function void promote(int unsigned f, int unsigned old_age);
            for (int unsigned i = 0; i < occupied; i++) begin
                if (i != f && frame_age[i] < old_age) frame_age[i]++;
            end
            frame_age[f] = 0;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] page);
            t_lookup_outcome o;
            bit              hit;
            int unsigned     slot;
            hit             = 1'b0;
            slot            = 0;
            o.evicted_valid = 1'b0;
            o.evicted_page  = '0;
            for (int unsigned i = 0; i < occupied; i++) begin
                if (!hit && frame_page[i] == page) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (hit) begin
                promote(slot, frame_age[slot]);
            end else begin
                if (occupied < frame_limit()) begin
                    slot = occupied;
                    occupied++;
                    frame_page[slot] = page;
                    promote(slot, NUM_FRAMES);
                end else begin
                    slot = 0;
                    for (int unsigned i = 1; i < occupied; i++) begin
                        if (frame_age[i] > frame_age[slot]) slot = i;
                    end
                    o.evicted_valid  = 1'b1;
                    o.evicted_page   = frame_page[slot];
                    frame_page[slot] = page;
                    promote(slot, frame_age[slot]);
                end
                if (faults != lrupr_pkg::COUNT_MAX) faults++;
            end
            o.page_fault     = !hit;
            o.frame_slot     = SLOT_W'(slot);
            o.resident_count = CFG_W'(occupied);
            o.fault_total    = faults;
            outcomes.insert(outcomes.size(), o);
        endfunction

        function void compare_field(string name, logic [COUNT_W-1:0] exp_v,
                                    logic [COUNT_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_lookup_outcome act);
            t_lookup_outcome e;
            if (outcomes.size() == 0) begin
                $error("result item with no reference outstanding");
                mismatches++;
                return;
            end
            e = outcomes.pop_front();
            compare_field("page_fault", COUNT_W'(e.page_fault), COUNT_W'(act.page_fault));
            compare_field("frame_slot", COUNT_W'(e.frame_slot), COUNT_W'(act.frame_slot));
            compare_field("evicted_valid", COUNT_W'(e.evicted_valid),
                          COUNT_W'(act.evicted_valid));
            compare_field("evicted_page", COUNT_W'(e.evicted_page), COUNT_W'(act.evicted_page));
            compare_field("resident_count", COUNT_W'(e.resident_count),
                          COUNT_W'(act.resident_count));
            compare_field("fault_total", e.fault_total, act.fault_total);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [PAGE_W-1:0]  i_page_number;
    logic               o_valid;
    logic               i_ready;
    logic               o_page_fault;
    logic [SLOT_W-1:0]  o_frame_slot;
    logic               o_evicted_valid;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [CFG_W-1:0]   o_resident_count;
    logic [COUNT_W-1:0] o_fault_total;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_data;

    t_lru_scoreboard    sb = new();
    logic [PAGE_W-1:0]  page_pool [POOL_SIZE];
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        quiet_cycles;

    lru_page_replacement_unit #(
        .MAX_FRAMES(NUM_FRAMES),
        .PAGE_BITS (PAGE_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_page_fault    (o_page_fault),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_resident_count(o_resident_count),
        .o_fault_total   (o_fault_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // input and result monitor, receiver stalls and stall watchdog
    always @(posedge i_clk) begin
        t_lookup_outcome seen;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_reference(i_page_number);
            if (o_valid && i_ready) begin
                seen.page_fault     = o_page_fault;
                seen.frame_slot     = o_frame_slot;
                seen.evicted_valid  = o_evicted_valid;
                seen.evicted_page   = o_evicted_page;
                seen.resident_count = o_resident_count;
                seen.fault_total    = o_fault_total;
                sb.check_result(seen);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        i_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_reference(input logic [PAGE_W-1:0] page);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_frames(value);
        i_cfg_we   <= 1'b0;
    endtask

    // working set of the frame limit plus up to three pages, some wider pool picks, some fresh pages
    function automatic logic [PAGE_W-1:0] pick_page(logic [CFG_W-1:0] frames_cfg);
        int unsigned span;
        int unsigned roll;
        int unsigned k;
        span = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
        span = span + $urandom_range(3);
        if (span > POOL_SIZE) span = POOL_SIZE;
        roll = $urandom_range(99);
        if (roll < 85) return page_pool[$urandom_range(span - 1)];
        if (roll < 95) return page_pool[$urandom_range(POOL_SIZE - 1)];
        k = $urandom_range(POOL_SIZE - 1);
        page_pool[k] = PAGE_W'($urandom);
        return page_pool[k];
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_page_number = '0;
        i_ready       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        quiet_cycles  = 0;
        send_idle_pct = 6;
        recv_idle_pct = 51;
        foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_PAGES[i]) send_reference(DIRECTED_PAGES[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p == 4) begin
                send_idle_pct = 51;
                recv_idle_pct = 6;
            end
            if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_frames(PHASE_FRAMES[p]);
            repeat (ITEMS_PER_PHASE) send_reference(pick_page(PHASE_FRAMES[p]));
        end
        drain();

        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* lru_page_replacement_unit.f */
design/lrupr_pkg.sv
design/lrupr_frame_table.sv
design/lru_page_replacement_unit.sv
tb/tb_top.sv
